// ===== sv/epsp_pkg.sv =====
package epsp_pkg;

  localparam int SAMPLES_PER_EDGE = 128;
  localparam int SPAN             = SAMPLES_PER_EDGE - 1;
  localparam int SPAN_W           = $clog2(SAMPLES_PER_EDGE);
  localparam int IDX_W            = 7;
  localparam int IW               = (SPAN_W > IDX_W) ? SPAN_W : IDX_W;

  // |n_k| <= 2^15 * SPAN
  localparam int MAG_W    = 16 + IW;
  localparam int NW       = MAG_W + 1;
  localparam int NORM_BIT = 26;
  localparam int SH_W     = $clog2(NORM_BIT + 1);
  localparam int NM_W     = (MAG_W > NORM_BIT + 1) ? MAG_W : NORM_BIT + 1;
  localparam int SUM_W    = 2 * NM_W + 2;
  localparam int SQ_N     = NM_W + 1;
  localparam int RT_W     = NM_W + 1;

  localparam int Q1_W = 15;
  localparam int N1_W = NM_W + 16;
  localparam int D1_W = NM_W + 2;

  localparam int W_W   = 32;
  localparam int WM_W  = 31;
  localparam int N2_W  = 49;
  localparam int D2_W  = 33;
  localparam int Q2_W  = 32;
  localparam int ONE_Q28 = 1 << 28;

  localparam int LAT = 13 + SQ_N + Q1_W + Q2_W;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_COS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIN = 1'd1;
  localparam logic signed [15:0] COS_RESET = 16'sd14378;
  localparam logic signed [15:0] SIN_RESET = 16'sd7855;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_POLE = 2'd2;

  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_MIN = 32'h8000_0000;

  typedef struct packed {
    logic signed [15:0] start_c0;
    logic signed [15:0] start_c1;
    logic signed [15:0] start_c2;
    logic signed [15:0] start_c3;
    logic signed [15:0] end_c0;
    logic signed [15:0] end_c1;
    logic signed [15:0] end_c2;
    logic signed [15:0] end_c3;
    logic [IDX_W-1:0]   sample_index;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] proj_x;
    logic signed [31:0] proj_y;
    logic signed [31:0] proj_z;
    logic [1:0]         status;
  } out_item_t;

endpackage

// ===== sv/epsp_ifs.sv =====
interface epsp_in_if import epsp_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface epsp_out_if import epsp_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/edge_point_stereo_projection_core.sv =====
// Depth: the square root (one root bit per stage) and the two restoring dividers (one
// quotient bit per stage) set the pipeline depth from input transfer to result.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset: synchronous, active low; clears the valid line and loads the default
// cosine and sine. Payload registers are not reset.
module edge_point_stereo_projection_core import epsp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  epsp_in_if.sink              in_ch,
  epsp_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_wdata
);

  typedef struct packed {
    logic [3:0][NM_W-1:0] nm;
    logic [3:0]           neg;
    logic                 zero;
  } nrm_t;

  typedef struct packed {
    nrm_t             p;
    logic [SUM_W-1:0] v;
    logic [SUM_W:0]   r;
  } sq_t;

  typedef struct packed {
    logic [3:0][N1_W-1:0] rem;
    logic [3:0][Q1_W-1:0] q;
    logic [D1_W-1:0]      dv;
    logic [3:0]           neg;
    logic                 zero;
  } d1_t;

  typedef struct packed {
    logic [2:0][N2_W-1:0] rem;
    logic [2:0][Q2_W-1:0] q;
    logic [D2_W-1:0]      dv;
    logic [2:0]           neg;
    logic [2:0]           nz;
    logic [2:0]           ovf;
    logic                 pole;
    logic                 zero;
  } d2_t;

  // ---------------------------------------------------------------------------
  // Config registers (the user must write them only while idle; the block does not enforce it)
  // ---------------------------------------------------------------------------
  logic signed [15:0] cos_r, sin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r <= COS_RESET;
      sin_r <= SIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COS: cos_r <= cfg_wdata;
        CFG_SIN: sin_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: one valid bit per stage, all stages move together.
  // ---------------------------------------------------------------------------
  logic [LAT-1:0] vld_r;
  logic           adv;

  assign adv          = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready  = adv;
  assign out_ch.valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_ch.valid};
    end
  end

  // ---------------------------------------------------------------------------
  // S1: scaled interpolation n_k = A_k*(N-1-i) + B_k*i
  // ---------------------------------------------------------------------------
  logic signed [15:0]   ca [4];
  logic signed [15:0]   cb [4];
  logic [IW-1:0]        idx_ext, idx_c;
  logic signed [IW:0]   wa, wb;
  logic signed [NW-1:0] n_nxt [4];
  logic signed [NW-1:0] n_r [4];

  assign ca[0] = in_ch.data.start_c0;
  assign ca[1] = in_ch.data.start_c1;
  assign ca[2] = in_ch.data.start_c2;
  assign ca[3] = in_ch.data.start_c3;
  assign cb[0] = in_ch.data.end_c0;
  assign cb[1] = in_ch.data.end_c1;
  assign cb[2] = in_ch.data.end_c2;
  assign cb[3] = in_ch.data.end_c3;

  // index past the end of the edge clamps to the last sample
  assign idx_ext = IW'(in_ch.data.sample_index);
  assign idx_c   = (idx_ext > IW'(SPAN)) ? IW'(SPAN) : idx_ext;
  assign wa      = signed'({1'b0, IW'(SPAN) - idx_c});
  assign wb      = signed'({1'b0, idx_c});

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      n_nxt[k] = NW'(ca[k] * wa) + NW'(cb[k] * wb);
    end
  end

  // ---------------------------------------------------------------------------
  // S2: magnitudes and OR of magnitudes (its MSB is the MSB of the max)
  // S3: normalizing shift amount, zero-vector flag
  // S4: apply shift
  // ---------------------------------------------------------------------------
  logic [MAG_W-1:0] mag_nxt [4];
  logic [MAG_W-1:0] or_nxt;
  logic [MAG_W-1:0] s2_mag_r [4];
  logic [3:0]       s2_neg_r;
  logic [MAG_W-1:0] s2_or_r;

  always_comb begin
    or_nxt = '0;
    for (int k = 0; k < 4; k++) begin
      mag_nxt[k] = n_r[k][NW-1] ? MAG_W'(-n_r[k]) : MAG_W'(n_r[k]);
      or_nxt     = or_nxt | mag_nxt[k];
    end
  end

  logic [SH_W-1:0]  sh_nxt;
  logic [MAG_W-1:0] s3_mag_r [4];
  logic [3:0]       s3_neg_r;
  logic             s3_zero_r;
  logic [SH_W-1:0]  s3_sh_r;

  always_comb begin
    int msb;
    msb = 0;
    for (int p = 0; p < MAG_W; p++) begin
      if (s2_or_r[p]) msb = p;
    end
    sh_nxt = (msb >= NORM_BIT) ? '0 : SH_W'(NORM_BIT - msb);
  end

  nrm_t s4_nxt, s4_r, s5_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      s4_nxt.nm[k] = NM_W'(s3_mag_r[k]) << s3_sh_r;
    end
    s4_nxt.neg  = s3_neg_r;
    s4_nxt.zero = s3_zero_r;
  end

  // ---------------------------------------------------------------------------
  // S5: squares, S6: sum of squares
  // ---------------------------------------------------------------------------
  logic [2*NM_W-1:0] sq_r [4];
  sq_t               sqs_r [SQ_N+1];
  sq_t               sqs0_nxt;

  always_comb begin
    sqs0_nxt.p = s5_r;
    sqs0_nxt.v = SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]) + SUM_W'(sq_r[3]);
    sqs0_nxt.r = '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_r       <= n_nxt;
      s2_mag_r  <= mag_nxt;
      s2_or_r   <= or_nxt;
      for (int k = 0; k < 4; k++) begin
        s2_neg_r[k] <= n_r[k][NW-1];
      end
      s3_mag_r  <= s2_mag_r;
      s3_neg_r  <= s2_neg_r;
      s3_zero_r <= (s2_or_r == '0);
      s3_sh_r   <= sh_nxt;
      s4_r      <= s4_nxt;
      s5_r      <= s4_r;
      for (int k = 0; k < 4; k++) begin
        sq_r[k] <= (2*NM_W)'(s4_r.nm[k] * s4_r.nm[k]);
      end
      sqs_r[0]  <= sqs0_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Integer square root, one root bit per stage (digit-by-digit)
  // ---------------------------------------------------------------------------
  for (genvar g = 1; g <= SQ_N; g++) begin : g_sqrt
    localparam int BP = 2 * (SQ_N - g);
    localparam logic [SUM_W:0] BITV = (SUM_W+1)'(1) << BP;
    sq_t nxt;

    always_comb begin
      logic [SUM_W:0] trial;
      nxt   = sqs_r[g-1];
      trial = sqs_r[g-1].r + BITV;
      if ({1'b0, sqs_r[g-1].v} >= trial) begin
        nxt.v = sqs_r[g-1].v - SUM_W'(trial);
        nxt.r = (sqs_r[g-1].r >> 1) + BITV;
      end else begin
        nxt.r = sqs_r[g-1].r >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) sqs_r[g] <= nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Normalize: u_k = round(|n_k| * 2^14 / r), restoring divider, 15 stages
  // ---------------------------------------------------------------------------
  logic [RT_W-1:0] root;
  d1_t             d1_r [Q1_W+1];
  d1_t             d1_0_nxt;

  assign root = RT_W'(sqs_r[SQ_N].r);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      d1_0_nxt.rem[k] = (N1_W'(sqs_r[SQ_N].p.nm[k]) << 15) + N1_W'(root);
    end
    d1_0_nxt.q    = '0;
    d1_0_nxt.dv   = D1_W'({root, 1'b0});
    d1_0_nxt.neg  = sqs_r[SQ_N].p.neg;
    d1_0_nxt.zero = sqs_r[SQ_N].p.zero;
  end

  always_ff @(posedge clk) begin
    if (adv) d1_r[0] <= d1_0_nxt;
  end

  for (genvar g = 1; g <= Q1_W; g++) begin : g_div1
    localparam int J = Q1_W - g;
    d1_t nxt;

    always_comb begin
      logic [N1_W-1:0] sub;
      nxt = d1_r[g-1];
      sub = N1_W'(d1_r[g-1].dv) << J;
      for (int k = 0; k < 4; k++) begin
        if (d1_r[g-1].rem[k] >= sub) begin
          nxt.rem[k]  = d1_r[g-1].rem[k] - sub;
          nxt.q[k][J] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) d1_r[g] <= nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Signed unit vector, rotation products, rotation sums and denominator
  // ---------------------------------------------------------------------------
  logic signed [15:0]    u_nxt [4];
  logic signed [15:0]    u_r [4];
  logic                  u_zero_r;
  logic signed [W_W-1:0] p_r [8];
  logic                  p_zero_r;
  logic signed [W_W-1:0] w_r [1:3];
  logic signed [D2_W-1:0] d_r;
  logic                  w_zero_r;

  always_comb begin
    logic signed [15:0] qs;
    for (int k = 0; k < 4; k++) begin
      qs       = signed'({1'b0, d1_r[Q1_W].q[k]});
      u_nxt[k] = d1_r[Q1_W].neg[k] ? -qs : qs;
    end
  end

  // P stage: magnitudes of w1..w3, pole flag, dividend and divisor
  logic [WM_W-1:0] wm_nxt [1:3];
  logic [2:0]      pneg_r, pnz_r;
  logic [N2_W-1:0] pn_r [3];
  logic [D2_W-1:0] pd_r;
  logic            ppole_r, pzero_r;
  logic            pole_nxt;

  assign pole_nxt = d_r[D2_W-1] || (d_r == '0);

  always_comb begin
    for (int k = 1; k <= 3; k++) begin
      wm_nxt[k] = w_r[k][W_W-1] ? WM_W'(-w_r[k]) : WM_W'(w_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u_r      <= u_nxt;
      u_zero_r <= d1_r[Q1_W].zero;
      p_r[0]   <= W_W'(cos_r * u_r[0]);
      p_r[1]   <= W_W'(sin_r * u_r[1]);
      p_r[2]   <= W_W'(sin_r * u_r[0]);
      p_r[3]   <= W_W'(cos_r * u_r[1]);
      p_r[4]   <= W_W'(cos_r * u_r[2]);
      p_r[5]   <= W_W'(sin_r * u_r[3]);
      p_r[6]   <= W_W'(sin_r * u_r[2]);
      p_r[7]   <= W_W'(cos_r * u_r[3]);
      p_zero_r <= u_zero_r;
      w_r[1]   <= p_r[2] + p_r[3];
      w_r[2]   <= p_r[4] - p_r[5];
      w_r[3]   <= p_r[6] + p_r[7];
      // d = 1 - w0 = 1 - c*u0 + s*u1, Q.28
      d_r      <= D2_W'(ONE_Q28) - D2_W'(p_r[0]) + D2_W'(p_r[1]);
      w_zero_r <= p_zero_r;
      for (int k = 1; k <= 3; k++) begin
        pneg_r[k-1] <= w_r[k][W_W-1];
        pnz_r[k-1]  <= (w_r[k] != '0);
        pn_r[k-1]   <= (N2_W'(wm_nxt[k]) << 17) + N2_W'(d_r[D2_W-2:0]);
      end
      pd_r     <= {d_r[D2_W-2:0], 1'b0};
      ppole_r  <= pole_nxt;
      pzero_r  <= w_zero_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Projection divide: overflow check, then 32 restoring stages
  // ---------------------------------------------------------------------------
  d2_t d2_r [Q2_W+1];
  d2_t d2_0_nxt;

  always_comb begin
    logic [D2_W+Q2_W-1:0] lim;
    lim = (D2_W+Q2_W)'(pd_r) << Q2_W;
    for (int k = 0; k < 3; k++) begin
      d2_0_nxt.rem[k] = pn_r[k];
      d2_0_nxt.ovf[k] = ((D2_W+Q2_W)'(pn_r[k]) >= lim);
    end
    d2_0_nxt.q    = '0;
    d2_0_nxt.dv   = pd_r;
    d2_0_nxt.neg  = pneg_r;
    d2_0_nxt.nz   = pnz_r;
    d2_0_nxt.pole = ppole_r;
    d2_0_nxt.zero = pzero_r;
  end

  always_ff @(posedge clk) begin
    if (adv) d2_r[0] <= d2_0_nxt;
  end

  for (genvar g = 1; g <= Q2_W; g++) begin : g_div2
    localparam int J = Q2_W - g;
    d2_t nxt;

    always_comb begin
      logic [D2_W+Q2_W-2:0] sub;
      nxt = d2_r[g-1];
      sub = (D2_W+Q2_W-1)'(d2_r[g-1].dv) << J;
      for (int k = 0; k < 3; k++) begin
        if ((D2_W+Q2_W-1)'(d2_r[g-1].rem[k]) >= sub) begin
          nxt.rem[k]  = d2_r[g-1].rem[k] - N2_W'(sub);
          nxt.q[k][J] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) d2_r[g] <= nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Sign, saturation and status; output register
  // ---------------------------------------------------------------------------
  out_item_t out_nxt, out_r;

  always_comb begin
    logic [31:0] val [3];
    logic        sat;
    d2_t         f;
    f   = d2_r[Q2_W];
    sat = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (f.pole) begin
        val[k] = !f.nz[k] ? 32'd0 : (f.neg[k] ? NEG_MIN : POS_MAX);
      end else if (!f.neg[k]) begin
        if (f.ovf[k] || f.q[k] > POS_MAX) begin
          val[k] = POS_MAX;
          sat    = 1'b1;
        end else begin
          val[k] = f.q[k];
        end
      end else begin
        if (f.ovf[k] || f.q[k] > NEG_MIN) begin
          val[k] = NEG_MIN;
          sat    = 1'b1;
        end else begin
          val[k] = 32'd0 - f.q[k];
        end
      end
    end
    out_nxt.proj_x = val[0];
    out_nxt.proj_y = val[1];
    out_nxt.proj_z = val[2];
    if (f.zero) begin
      out_nxt.proj_x = '0;
      out_nxt.proj_y = '0;
      out_nxt.proj_z = '0;
      out_nxt.status = ST_ZERO;
    end else if (f.pole || sat) begin
      out_nxt.status = ST_POLE;
    end else begin
      out_nxt.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_r <= out_nxt;
  end

  assign out_ch.data = out_r;

endmodule
